// ----- hw/rtl/svk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svk_pkg
// shared constants, types and helpers for the svk stress unit
// ----------------------------------------------------------------------------
package svk_pkg;

	localparam int IN_FRAC_BITS  = 28;
	localparam int OUT_FRAC_BITS = 40;
	localparam int LAME_FRAC     = 16;
	localparam logic [31:0] MODULUS_RESET = 32'd65536;

	typedef enum logic [0:0] {
		REG_SHEAR = 1'b0,
		REG_LAMBDA = 1'b1
	} reg_idx_t;

	typedef logic signed [63:0] s64_t;

	function automatic s64_t sat128(input logic signed [127:0] v);
		if (v > 128'sh7FFFFFFFFFFFFFFF)
			return 64'sh7FFFFFFFFFFFFFFF;
		else if (v < -128'sh8000000000000000)
			return 64'sh8000000000000000;
		else
			return v[63:0];
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/svk_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svk_if
// valid/ready channel interfaces for the svk stress unit
// ----------------------------------------------------------------------------
interface svk_grad_if;
	logic valid;
	logic ready;
	logic signed [31:0] grad_00, grad_01, grad_02;
	logic signed [31:0] grad_10, grad_11, grad_12;
	logic signed [31:0] grad_20, grad_21, grad_22;
	logic linear_mode;
	modport source (output valid, grad_00, grad_01, grad_02, grad_10, grad_11, grad_12,
		grad_20, grad_21, grad_22, linear_mode, input ready);
	modport sink (input valid, grad_00, grad_01, grad_02, grad_10, grad_11, grad_12,
		grad_20, grad_21, grad_22, linear_mode, output ready);
endinterface

interface svk_row_if;
	logic valid;
	logic ready;
	logic [1:0] row_index;
	logic signed [63:0] s_col0, s_col1, s_col2;
	logic signed [63:0] p_col0, p_col1, p_col2;
	logic last_row;
	modport source (output valid, row_index, s_col0, s_col1, s_col2, p_col0, p_col1,
		p_col2, last_row, input ready);
	modport sink (input valid, row_index, s_col0, s_col1, s_col2, p_col0, p_col1,
		p_col2, last_row, output ready);
endinterface

interface svk_cfg_if;
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/svk_row.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svk_row
// per-row stress pipeline: strain row, S row, P row over registered stages
// ----------------------------------------------------------------------------
module svk_row #(
	parameter int IN_FRAC  = svk_pkg::IN_FRAC_BITS,
	parameter int OUT_FRAC = svk_pkg::OUT_FRAC_BITS
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               en,
	input  wire               in_valid,
	input  wire  [1:0]        in_row,
	input  wire  signed [31:0] h [3][3],
	input  wire               in_lin,
	input  wire  [31:0]       mu,
	input  wire  [31:0]       lam,
	output logic              out_valid,
	output logic [1:0]        out_row,
	output svk_pkg::s64_t     s_row [3],
	output svk_pkg::s64_t     p_row [3]
);
	localparam int SF = IN_FRAC + 17;

	// stage 1: rounded products for the strain row and trace diagonals
	logic               v_s1, lin_s1;
	logic [1:0]         row_s1;
	logic signed [31:0] h_s1 [3][3];
	logic signed [63:0] prod_s1 [3][3];
	logic signed [63:0] dprod_s1 [3][3];
	// stage 2: T row and trace
	logic               v_s2, lin_s2;
	logic [1:0]         row_s2;
	logic signed [31:0] h_s2 [3][3];
	logic signed [39:0] t_s2 [3];
	logic signed [41:0] tr_s2;
	// stage 3: S row
	logic               v_s3, lin_s3;
	logic [1:0]         row_s3;
	logic signed [31:0] h_s3 [3][3];
	svk_pkg::s64_t      s_s3 [3];
	// stage 4: S*H^T partial products, low and high halves of S
	logic               v_s4, lin_s4;
	logic [1:0]         row_s4;
	svk_pkg::s64_t      s_s4 [3];
	logic signed [64:0] shl_s4 [3][3];
	logic signed [63:0] shh_s4 [3][3];

	function automatic logic signed [63:0] rnd_in(input logic signed [63:0] p);
		logic signed [63:0] q;
		q = p + (64'sd1 <<< (IN_FRAC - 1));
		return q >>> IN_FRAC;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			row_s1 <= in_row;
			lin_s1 <= in_lin;
			h_s1 <= h;
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 3; k++) begin
					prod_s1[j][k] <= rnd_in(64'(h[k][in_row]) * 64'(h[k][j]));
					dprod_s1[j][k] <= rnd_in(64'(h[k][j]) * 64'(h[k][j]));
				end
			// stage 2
			row_s2 <= row_s1;
			lin_s2 <= lin_s1;
			h_s2 <= h_s1;
			for (int j = 0; j < 3; j++)
				t_s2[j] <= 40'(h_s1[row_s1][j]) + 40'(h_s1[j][row_s1])
					+ 40'(prod_s1[j][0]) + 40'(prod_s1[j][1]) + 40'(prod_s1[j][2]);
			tr_s2 <= 42'(2 * (42'(h_s1[0][0]) + 42'(h_s1[1][1]) + 42'(h_s1[2][2])))
				+ 42'(dprod_s1[0][0]) + 42'(dprod_s1[0][1]) + 42'(dprod_s1[0][2])
				+ 42'(dprod_s1[1][0]) + 42'(dprod_s1[1][1]) + 42'(dprod_s1[1][2])
				+ 42'(dprod_s1[2][0]) + 42'(dprod_s1[2][1]) + 42'(dprod_s1[2][2]);
			// stage 3
			row_s3 <= row_s2;
			lin_s3 <= lin_s2;
			h_s3 <= h_s2;
			for (int j = 0; j < 3; j++) begin
				logic signed [127:0] acc;
				logic signed [127:0] r;
				acc = 128'(2) * (128'($signed({1'b0, mu})) * 128'(t_s2[j]));
				if (2'(j) == row_s2)
					acc = acc + 128'($signed({1'b0, lam})) * 128'(tr_s2);
				if (SF >= OUT_FRAC) begin
					if (SF > OUT_FRAC)
						r = (acc + (128'sd1 <<< (SF - OUT_FRAC - 1))) >>> (SF - OUT_FRAC);
					else
						r = acc;
				end else
					r = acc <<< (OUT_FRAC - SF);
				s_s3[j] <= svk_pkg::sat128(r);
			end
			// stage 4
			row_s4 <= row_s3;
			lin_s4 <= lin_s3;
			s_s4 <= s_s3;
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 3; k++) begin
					shl_s4[j][k] <= 65'($signed({1'b0, s_s3[k][31:0]})) * 65'(h_s3[j][k]);
					shh_s4[j][k] <= 64'($signed(s_s3[k][63:32])) * 64'(h_s3[j][k]);
				end
			// stage 5
			out_row <= row_s4;
			s_row <= s_s4;
			for (int j = 0; j < 3; j++) begin
				logic signed [127:0] a;
				a = (128'(s_s4[j]) <<< IN_FRAC)
					+ (128'(shh_s4[j][0]) <<< 32) + 128'(shl_s4[j][0])
					+ (128'(shh_s4[j][1]) <<< 32) + 128'(shl_s4[j][1])
					+ (128'(shh_s4[j][2]) <<< 32) + 128'(shl_s4[j][2]);
				a = (a + (128'sd1 <<< (IN_FRAC - 1))) >>> IN_FRAC;
				p_row[j] <= lin_s4 ? s_s4[j] : svk_pkg::sat128(a);
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/svk_stress_from_displacement_gradient_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svk_stress_from_displacement_gradient_unit
// saint venant-kirchhoff stress rows from a 3x3 displacement gradient
// ----------------------------------------------------------------------------
// channel  role  payload
// grad     sink  grad_00..grad_22, linear_mode
// rows     src   row_index, s_col0..2, p_col0..2, last_row
// cfg      sink  index, data
// a beat is taken once the previous beat fed its last row; each beat sends
// one row per cycle, unless rows stalls, down a five-stage row pipeline
// reset clears valid bits and sets both moduli to 1.0
// a stall on the row side freezes the whole pipeline; nothing is dropped
// ----------------------------------------------------------------------------
module svk_stress_from_displacement_gradient_unit #(
	parameter int IN_FRAC_BITS  = svk_pkg::IN_FRAC_BITS,
	parameter int OUT_FRAC_BITS = svk_pkg::OUT_FRAC_BITS
) (
	input wire       clk,
	input wire       arst_n,
	svk_grad_if.sink grad,
	svk_row_if.source rows,
	svk_cfg_if.sink  cfg
);
	logic [31:0] mu_q, lam_q;
	logic        hold_q;
	logic [1:0]  cnt_q;
	logic signed [31:0] h_q [3][3];
	logic signed [31:0] hin [3][3];
	logic        lin_q;
	logic        en, feed_valid, pipe_valid;
	logic [1:0]  feed_row, pipe_row;
	logic signed [31:0] feed_h [3][3];
	logic        feed_lin;
	svk_pkg::s64_t s_row [3], p_row [3];

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= svk_pkg::MODULUS_RESET;
			lam_q <= svk_pkg::MODULUS_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				svk_pkg::REG_SHEAR:  mu_q <= cfg.data;
				svk_pkg::REG_LAMBDA: lam_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign hin = '{'{grad.grad_00, grad.grad_01, grad.grad_02},
		'{grad.grad_10, grad.grad_11, grad.grad_12},
		'{grad.grad_20, grad.grad_21, grad.grad_22}};

	assign en = !rows.valid || rows.ready;
	assign grad.ready = en && (!hold_q || cnt_q == 2'd2);
	assign feed_valid = hold_q || grad.valid;
	assign feed_row = hold_q ? cnt_q + 2'd1 : 2'd0;
	assign feed_h = hold_q ? h_q : hin;
	assign feed_lin = hold_q ? lin_q : grad.linear_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			cnt_q <= 2'd0;
		end else if (en) begin
			if (grad.valid && grad.ready) begin
				hold_q <= 1'b1;
				cnt_q <= 2'd0;
			end else if (hold_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd1)
					hold_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grad.valid && grad.ready) begin
			h_q <= hin;
			lin_q <= grad.linear_mode;
		end
	end

	svk_row #(.IN_FRAC(IN_FRAC_BITS), .OUT_FRAC(OUT_FRAC_BITS)) u_row (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(feed_valid), .in_row(feed_row),
		.h(feed_h), .in_lin(feed_lin), .mu(mu_q), .lam(lam_q),
		.out_valid(pipe_valid), .out_row(pipe_row), .s_row(s_row), .p_row(p_row)
	);

	assign rows.valid = pipe_valid;
	assign rows.row_index = pipe_row;
	assign rows.last_row = (pipe_row == 2'd2);
	assign rows.s_col0 = s_row[0];
	assign rows.s_col1 = s_row[1];
	assign rows.s_col2 = s_row[2];
	assign rows.p_col0 = p_row[0];
	assign rows.p_col1 = p_row[1];
	assign rows.p_col2 = p_row[2];

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q |-> cnt_q != 2'd3) else $error("row counter out of range");
	a_no_accept_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_q && cnt_q == 2'd0) |-> !grad.ready) else $error("accept mid item");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rows.valid && !rows.ready) |=> $stable(pipe_row)) else $error("row moved in stall");
endmodule
`default_nettype wire
